// File: hdl/srs_pkg.sv
// shared types, constants and command structs of the stable record sorter
package srs_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int ID_W        = 24;
  localparam int YEAR_W      = 12;
  localparam int SEM_W       = 4;
  localparam int GRADE_W     = 9;
  localparam int CRED_W      = 8;
  localparam int KEY_W       = YEAR_W + ID_W + IDX_W;

  localparam logic [GRADE_W-1:0] GRADE_MAX = GRADE_W'(400);

  typedef struct packed {
    logic [ID_W-1:0]    student_id;
    logic [YEAR_W-1:0]  enroll_year;
    logic [SEM_W-1:0]   semester;
    logic [GRADE_W-1:0] grade_hundredths;
    logic [CRED_W-1:0]  credit_hours;
    logic               is_last;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]    out_id;
    logic [YEAR_W-1:0]  out_year;
    logic [SEM_W-1:0]   out_semester;
    logic [GRADE_W-1:0] out_grade;
    logic [CRED_W-1:0]  out_credits;
    logic               out_last;
    logic               overflowed;
  } out_item_t;

  // one stored entry, 57 bits
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [YEAR_W-1:0]  year;
    logic [SEM_W-1:0]   sem;
    logic [GRADE_W-1:0] grade;
    logic [CRED_W-1:0]  credits;
  } rec_t;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic last_out;
  } status_t;

endpackage

// File: hdl/srs_in_if.sv
// request channel carrying one input record
interface srs_in_if;
  import srs_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/srs_out_if.sv
// request channel carrying one sorted result record
interface srs_out_if;
  import srs_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/srs_datapath.sv
// record store, selection scan and result registers of the sorter
module srs_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srs_pkg::cmd_t      cmd_i,
  input  srs_pkg::in_item_t  item_i,
  output srs_pkg::status_t   status_o,
  output srs_pkg::out_item_t result_o
);
  import srs_pkg::*;

  rec_t             mem_q [MAX_RECORDS];
  rec_t             rd_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             rd_pend_q;

  logic [CNT_W-1:0] count_q;
  logic             ovf_q;
  logic [CNT_W-1:0] scan_idx_q;
  logic [CNT_W-1:0] emitted_q;

  rec_t             best_q;
  logic [IDX_W-1:0] best_idx_q;
  logic             best_vld_q;
  key_t             last_key_q;
  logic             last_vld_q;

  logic             full;
  logic             issue;
  rec_t             new_rec;
  key_t             cand_key;
  key_t             best_key;
  logic             take;

  assign full  = (count_q == CNT_W'(MAX_RECORDS));
  assign issue = cmd_i.scan && (scan_idx_q < count_q);

  always_comb begin
    new_rec.id      = item_i.student_id;
    new_rec.year    = item_i.enroll_year;
    new_rec.sem     = item_i.semester;
    new_rec.grade   = (item_i.grade_hundredths > GRADE_MAX) ? GRADE_MAX
                                                            : item_i.grade_hundredths;
    new_rec.credits = item_i.credit_hours;
  end

  // arrival index in the low bits makes every key unique and keeps ties stable
  assign cand_key = {rd_q.year, rd_q.id, rd_idx_q};
  assign best_key = {best_q.year, best_q.id, best_idx_q};
  assign take     = rd_pend_q && (!last_vld_q || (cand_key > last_key_q))
                    && (!best_vld_q || (cand_key < best_key));

  // store in arrival order
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      mem_q[count_q[IDX_W-1:0]] <= new_rec;
    end
    if (issue) begin
      rd_q <= mem_q[scan_idx_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      ovf_q      <= 1'b0;
      scan_idx_q <= '0;
      emitted_q  <= '0;
      rd_pend_q  <= 1'b0;
      rd_idx_q   <= '0;
      best_q     <= '0;
      best_idx_q <= '0;
      best_vld_q <= 1'b0;
      last_key_q <= '0;
      last_vld_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CNT_W'(1);
        end
      end
      if (cmd_i.scan_start) begin
        scan_idx_q <= '0;
        rd_pend_q  <= 1'b0;
        best_vld_q <= 1'b0;
      end else if (cmd_i.scan) begin
        rd_pend_q <= issue;
        if (issue) begin
          rd_idx_q   <= scan_idx_q[IDX_W-1:0];
          scan_idx_q <= scan_idx_q + CNT_W'(1);
        end
        if (take) begin
          best_q     <= rd_q;
          best_idx_q <= rd_idx_q;
          best_vld_q <= 1'b1;
        end
      end
      if (cmd_i.pop) begin
        last_key_q <= best_key;
        if (status_o.last_out) begin
          count_q    <= '0;
          ovf_q      <= 1'b0;
          emitted_q  <= '0;
          last_vld_q <= 1'b0;
        end else begin
          emitted_q  <= emitted_q + CNT_W'(1);
          last_vld_q <= 1'b1;
        end
      end
    end
  end

  assign status_o.scan_done = (scan_idx_q == count_q) && !rd_pend_q;
  assign status_o.last_out  = ((emitted_q + CNT_W'(1)) == count_q);

  always_comb begin
    result_o.out_id       = best_q.id;
    result_o.out_year     = best_q.year;
    result_o.out_semester = best_q.sem;
    result_o.out_grade    = best_q.grade;
    result_o.out_credits  = best_q.credits;
    result_o.out_last     = status_o.last_out;
    result_o.overflowed   = ovf_q;
  end

endmodule

// File: hdl/srs_ctrl.sv
// sequencer: load records, then one selection scan per sorted result
module srs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  srs_pkg::status_t status_i,
  output srs_pkg::cmd_t    cmd_o
);
  import srs_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_OUT
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   in_acc;
  logic   out_acc;

  assign in_ready_o  = (state_q == ST_LOAD);
  assign out_valid_o = (state_q == ST_OUT);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_ready_i && out_valid_o;

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    case (state_q)
      ST_LOAD: begin
        cmd_o.load = in_acc;
        if (in_acc && in_last_i) begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          cmd_o.pop = 1'b1;
          if (status_i.last_out) begin
            state_d = ST_LOAD;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/stable_record_sort_by_year_id_core.sv
// Stable sort of records by enroll year then id: one record accepted per cycle while loading.
// After the closing request each result takes one selection scan of the store (one store read port).
// No new record is accepted until the last result of the run has been taken.
// Reset clears the record count, the overflow flag and the sequencer; the store is not cleared.
module stable_record_sort_by_year_id_core (
  input  logic clk_i,
  input  logic rst_ni,
  srs_in_if.sink    in_i,
  srs_out_if.source out_o
);
  import srs_pkg::*;

  cmd_t    cmd;
  status_t status;

  srs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.payload.is_last),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  srs_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (in_i.payload),
    .status_o (status),
    .result_o (out_o.payload)
  );

endmodule

// File: test/stable_record_sort_by_year_id_core_test.sv
// self-checking testbench for the stable year/id record sorter: directed table then random sets
`timescale 1ns / 100ps

module stable_record_sort_by_year_id_core_test;
  import srs_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS   = 188;
  localparam int DRAIN_CYCLES   = 200;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  srs_in_if  in_bus ();
  srs_out_if out_bus ();

  stable_record_sort_by_year_id_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // predictor state: records of the open set, kept sorted
  rec_t      held_recs[$];
  bit        dropped_flag;
  out_item_t run_results[$];
  out_item_t sorted_due[$];
  stim_row_t directed_rows[$];
  int        err_count;
  bit        calm_phase;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic in_item_t mk_item(logic [ID_W-1:0] id, logic [YEAR_W-1:0] year,
                                       logic [SEM_W-1:0] sem, logic [GRADE_W-1:0] grade,
                                       logic [CRED_W-1:0] cred, logic last);
    in_item_t it;
    it.student_id       = id;
    it.enroll_year      = year;
    it.semester         = sem;
    it.grade_hundredths = grade;
    it.credit_hours     = cred;
    it.is_last          = last;
    return it;
  endfunction

  function automatic out_item_t mk_out(logic [ID_W-1:0] id, logic [YEAR_W-1:0] year,
                                       logic [SEM_W-1:0] sem, logic [GRADE_W-1:0] grade,
                                       logic [CRED_W-1:0] cred, logic last, logic ovf);
    out_item_t o;
    o.out_id       = id;
    o.out_year     = year;
    o.out_semester = sem;
    o.out_grade    = grade;
    o.out_credits  = cred;
    o.out_last     = last;
    o.overflowed   = ovf;
    return o;
  endfunction

  function automatic bit key_after(rec_t a, rec_t b);
    if (a.year != b.year) return a.year > b.year;
    return a.id > b.id;
  endfunction

  // insert one record stably; on the closing request emit the whole sorted run
  function automatic void place_and_close(in_item_t it);
    rec_t      r;
    int        pos;
    out_item_t o;
    r.id      = it.student_id;
    r.year    = it.enroll_year;
    r.sem     = it.semester;
    r.grade   = (it.grade_hundredths > GRADE_MAX) ? GRADE_MAX : it.grade_hundredths;
    r.credits = it.credit_hours;
    run_results.delete();
    if (held_recs.size() >= MAX_RECORDS) begin
      dropped_flag = 1'b1;
    end else begin
      pos = held_recs.size();
      while (pos > 0 && key_after(held_recs[pos-1], r)) pos--;
      held_recs.insert(pos, r);
    end
    if (it.is_last) begin
      foreach (held_recs[k]) begin
        o = mk_out(held_recs[k].id, held_recs[k].year, held_recs[k].sem, held_recs[k].grade,
                   held_recs[k].credits, k == held_recs.size() - 1, dropped_flag);
        run_results.push_back(o);
      end
      held_recs.delete();
      dropped_flag = 1'b0;
    end
  endfunction

  function automatic int idle_gap();
    int r;
    if (calm_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // keys crowd onto a few values so that ties are common
  function automatic in_item_t rand_record(logic last);
    logic [ID_W-1:0]   id;
    logic [YEAR_W-1:0] year;
    if ($urandom_range(0, 3) == 0) year = YEAR_W'($urandom_range(0, 4095));
    else year = YEAR_W'(2000 + $urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) id = ID_W'($urandom);
    else id = ID_W'($urandom_range(0, 7));
    return mk_item(id, year, SEM_W'($urandom_range(0, 15)), GRADE_W'($urandom_range(0, 511)),
                   CRED_W'($urandom_range(0, 255)), last);
  endfunction

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %0h want %0h", $time, what, got, want);
    err_count++;
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(in_item_t it, bit typed, out_item_t want);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid   <= 1'b1;
    in_bus.payload <= it;
    do @(posedge clk_i); while (!(in_bus.valid && in_bus.ready));
    place_and_close(it);
    if (typed) sorted_due.push_back(want);
    else foreach (run_results[k]) sorted_due.push_back(run_results[k]);
    @(negedge clk_i);
  endtask

  // result side back-pressure
  initial begin
    int stall_left;
    int r;
    out_bus.ready = 1'b0;
    stall_left    = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
        r = $urandom_range(0, 99);
        if (!calm_phase && r < 20) stall_left = $urandom_range(1, 3);
        else if (!calm_phase && r < 23) stall_left = $urandom_range(10, 50);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    out_item_t got;
    out_item_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got = out_bus.payload;
      if (sorted_due.size() == 0) begin
        note_mismatch("unexpected result, id", 32'(got.out_id), 32'h0);
      end else begin
        want = sorted_due.pop_front();
        if (got.out_id != want.out_id)
          note_mismatch("out_id", 32'(got.out_id), 32'(want.out_id));
        if (got.out_year != want.out_year)
          note_mismatch("out_year", 32'(got.out_year), 32'(want.out_year));
        if (got.out_semester != want.out_semester)
          note_mismatch("out_semester", 32'(got.out_semester), 32'(want.out_semester));
        if (got.out_grade != want.out_grade)
          note_mismatch("out_grade", 32'(got.out_grade), 32'(want.out_grade));
        if (got.out_credits != want.out_credits)
          note_mismatch("out_credits", 32'(got.out_credits), 32'(want.out_credits));
        if (got.out_last != want.out_last)
          note_mismatch("out_last", 32'(got.out_last), 32'(want.out_last));
        if (got.overflowed != want.overflowed)
          note_mismatch("overflowed", 32'(got.overflowed), 32'(want.overflowed));
      end
    end
  end

  // ends the run after a long stretch with no request moving on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int sent;
    int set_no;
    int set_len;
    in_bus.valid   = 1'b0;
    in_bus.payload = '0;
    rst_ni         = 1'b0;
    err_count      = 0;
    dropped_flag   = 1'b0;
    calm_phase     = 1'b0;

    // single-record sets: the result is the record itself, with the grade clamped to 400
    directed_rows.push_back('{mk_item(24'h0, 12'h0, 4'h0, 9'd0, 8'h0, 1'b1), 1'b1,
                              mk_out(24'h0, 12'h0, 4'h0, 9'd0, 8'h0, 1'b1, 1'b0)});
    directed_rows.push_back('{mk_item(24'hFFFFFF, 12'hFFF, 4'hF, 9'd511, 8'hFF, 1'b1), 1'b1,
                              mk_out(24'hFFFFFF, 12'hFFF, 4'hF, 9'd400, 8'hFF, 1'b1, 1'b0)});
    directed_rows.push_back('{mk_item(24'h800000, 12'h800, 4'h8, 9'd256, 8'h80, 1'b1), 1'b1,
                              mk_out(24'h800000, 12'h800, 4'h8, 9'd256, 8'h80, 1'b1, 1'b0)});
    directed_rows.push_back('{mk_item(24'h555555, 12'hAAA, 4'h5, 9'd401, 8'h55, 1'b1), 1'b1,
                              mk_out(24'h555555, 12'hAAA, 4'h5, 9'd400, 8'h55, 1'b1, 1'b0)});
    directed_rows.push_back('{mk_item(24'hAAAAAA, 12'h555, 4'hA, 9'd400, 8'hAA, 1'b1), 1'b1,
                              mk_out(24'hAAAAAA, 12'h555, 4'hA, 9'd400, 8'hAA, 1'b1, 1'b0)});
    // mixed keys with exact ties, closed by a tie
    directed_rows.push_back('{mk_item(24'd5, 12'd2000, 4'd1, 9'd300, 8'd10, 1'b0), 1'b0, '0});
    directed_rows.push_back('{mk_item(24'd3, 12'd2000, 4'd2, 9'd250, 8'd20, 1'b0), 1'b0, '0});
    directed_rows.push_back('{mk_item(24'd5, 12'd2000, 4'd3, 9'd100, 8'd30, 1'b0), 1'b0, '0});
    directed_rows.push_back('{mk_item(24'd0, 12'd4095, 4'd4, 9'd0, 8'd40, 1'b0), 1'b0, '0});
    directed_rows.push_back('{mk_item(24'hFFFFFF, 12'd0, 4'd5, 9'd450, 8'd50, 1'b0), 1'b0, '0});
    directed_rows.push_back('{mk_item(24'd5, 12'd1999, 4'd6, 9'd399, 8'd60, 1'b0), 1'b0, '0});
    directed_rows.push_back('{mk_item(24'd5, 12'd2000, 4'd7, 9'd200, 8'd70, 1'b1), 1'b0, '0});
    // years arriving in falling order
    for (int n = 0; n < 5; n++)
      directed_rows.push_back('{mk_item(ID_W'(n), YEAR_W'(40 - 10 * n), 4'd9, 9'd123,
                                        CRED_W'(n), n == 4), 1'b0, '0});
    // identical keys: payload order must survive
    for (int n = 0; n < 4; n++)
      directed_rows.push_back('{mk_item(24'h123456, 12'd2024, SEM_W'(n), GRADE_W'(100 * n),
                                        CRED_W'(n), n == 3), 1'b0, '0});
    directed_rows.push_back('{mk_item(24'h000001, 12'h001, 4'h1, 9'd1, 8'h01, 1'b1), 1'b1,
                              mk_out(24'h000001, 12'h001, 4'h1, 9'd1, 8'h01, 1'b1, 1'b0)});

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    // random sets, one exactly full and one overflowing past the closing request
    sent   = 0;
    set_no = 0;
    while (sent < RANDOM_ITEMS) begin
      if (set_no == 2) set_len = MAX_RECORDS;
      else if (set_no == 6) set_len = MAX_RECORDS + 2;
      else if ($urandom_range(0, 4) == 0) set_len = $urandom_range(9, 16);
      else set_len = $urandom_range(1, 8);
      calm_phase = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < set_len; n++)
        send_request(rand_record(n == set_len - 1), 1'b0, '0);
      sent += set_len;
      set_no++;
    end
    in_bus.valid <= 1'b0;

    while (sorted_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
